### hw/rtl/tme_pkg.sv
package tme_pkg;

	localparam int MAX_RULES_DEF  = 64;
	localparam int TAPE_CELLS_DEF = 256;
	localparam int STATE_BITS_DEF = 8;

	localparam int SYM_W  = 8;
	localparam int HEAD_W = 10;

	localparam logic [1:0] OP_RULE  = 2'd0;
	localparam logic [1:0] OP_CELL  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STEP  = 2'd3;

	localparam logic [2:0] ST_DONE_OK   = 3'd0;
	localparam logic [2:0] ST_STEPPED   = 3'd1;
	localparam logic [2:0] ST_NO_RULE   = 3'd2;
	localparam logic [2:0] ST_OFF_TAPE  = 3'd3;
	localparam logic [2:0] ST_WAS_HALT  = 3'd4;

	localparam logic [1:0] CFG_RULE_COUNT  = 2'd0;
	localparam logic [1:0] CFG_TAPE_LENGTH = 2'd1;
	localparam logic [1:0] CFG_START_HEAD  = 2'd2;

	localparam logic [6:0] RULE_COUNT_RST  = 7'd0;
	localparam logic [8:0] TAPE_LENGTH_RST = 9'd256;
	localparam logic [8:0] START_HEAD_RST  = 9'd1;

	typedef struct packed {
		logic [6:0] rule_count;
		logic [8:0] tape_length;
		logic [8:0] start_head;
	} cfg_t;

endpackage

### hw/rtl/tme_ram.sv
module tme_ram
	import tme_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/tme_ctrl.sv
module tme_ctrl
	import tme_pkg::*;
#(
	parameter int MAX_RULES  = MAX_RULES_DEF,
	parameter int TAPE_CELLS = TAPE_CELLS_DEF,
	parameter int STATE_BITS = STATE_BITS_DEF,
	parameter int RULE_W     = 2 * STATE_BITS + 2 * SYM_W + 1,
	parameter int RULE_AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
	parameter int TAPE_AW    = $clog2(TAPE_CELLS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         op,
	input  logic [7:0]         slot,
	input  logic [7:0]         rule_state,
	input  logic [7:0]         rule_symbol,
	input  logic [7:0]         write_symbol,
	input  logic               move_right,
	input  logic [7:0]         rule_next_state,
	input  logic [7:0]         cell_value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic [8:0]         head_position,
	output logic [7:0]         machine_state,
	output logic [7:0]         read_symbol,
	output logic               rule_we,
	output logic [RULE_AW-1:0] rule_waddr,
	output logic [RULE_W-1:0]  rule_wdata,
	output logic               rule_re,
	output logic [RULE_AW-1:0] rule_raddr,
	input  logic [RULE_W-1:0]  rule_rdata,
	output logic               tape_we,
	output logic [TAPE_AW-1:0] tape_waddr,
	output logic [SYM_W-1:0]   tape_wdata,
	output logic               tape_re,
	output logic [TAPE_AW-1:0] tape_raddr,
	input  logic [SYM_W-1:0]   tape_rdata
);

	localparam int RC_W = $clog2(MAX_RULES + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_TREAD = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	typedef struct packed {
		logic [STATE_BITS-1:0] st;
		logic [SYM_W-1:0]      sym;
		logic [SYM_W-1:0]      wr;
		logic                  right;
		logic [STATE_BITS-1:0] nxt;
	} rule_t;

	logic [1:0]            state_q;
	logic [HEAD_W-1:0]     head_q;
	logic [STATE_BITS-1:0] cur_q;
	logic                  halted_q;
	logic [RC_W-1:0]       idx_q;
	logic [SYM_W-1:0]      rd_q;
	logic [2:0]            res_status_q;
	logic [SYM_W-1:0]      res_rd_q;
	logic                  rsp_valid_q;
	logic [2:0]            rsp_status_q;
	logic [8:0]            rsp_head_q;
	logic [7:0]            rsp_state_q;
	logic [7:0]            rsp_rd_q;

	logic                  acc;
	logic                  out_free;
	logic [HEAD_W-1:0]     len;
	logic [RC_W-1:0]       nrules;
	logic [RC_W-1:0]       idx_inc;
	logic [31:0]           slot_ext;
	logic [31:0]           head_m1;
	logic [31:0]           rst_ext;
	logic [31:0]           nst_ext;
	logic [31:0]           cur_ext;
	logic                  slot_rule_ok;
	logic                  slot_tape_ok;
	logic                  head_off;
	logic [TAPE_AW-1:0]    head_taddr;
	rule_t                 rule;
	rule_t                 new_rule;
	logic                  match;
	logic [HEAD_W-1:0]     new_head;
	logic                  new_off;

	assign acc      = req_valid && (state_q == S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);

	assign len = (32'(cfg.tape_length) < 32'(TAPE_CELLS)) ? HEAD_W'(cfg.tape_length)
		: HEAD_W'(TAPE_CELLS);
	assign nrules = (32'(cfg.rule_count) < 32'(MAX_RULES)) ? RC_W'(cfg.rule_count)
		: RC_W'(MAX_RULES);
	assign idx_inc = idx_q + RC_W'(1);

	assign slot_ext     = 32'(slot);
	assign slot_rule_ok = slot_ext < 32'(MAX_RULES);
	assign slot_tape_ok = slot_ext < 32'(TAPE_CELLS);
	assign head_m1      = 32'(head_q) - 32'd1;
	assign head_taddr   = head_m1[TAPE_AW-1:0];
	assign head_off     = (head_q == '0) || (head_q > len);

	assign rst_ext = 32'(rule_state);
	assign nst_ext = 32'(rule_next_state);
	assign cur_ext = 32'(cur_q);

	always_comb begin
		new_rule.st    = rst_ext[STATE_BITS-1:0];
		new_rule.sym   = rule_symbol;
		new_rule.wr    = write_symbol;
		new_rule.right = move_right;
		new_rule.nxt   = nst_ext[STATE_BITS-1:0];
	end

	assign rule     = rule_t'(rule_rdata);
	assign match    = (rule.st == cur_q) && (rule.sym == rd_q);
	assign new_head = rule.right ? (head_q + HEAD_W'(1)) : (head_q - HEAD_W'(1));
	assign new_off  = (new_head == '0) || (new_head > len);

	assign rule_we    = acc && (op == OP_RULE) && slot_rule_ok;
	assign rule_waddr = slot_ext[RULE_AW-1:0];
	assign rule_wdata = RULE_W'(new_rule);

	always_comb begin
		rule_re    = 1'b0;
		rule_raddr = '0;
		if (state_q == S_TREAD) begin
			rule_re = (nrules != '0);
		end else if (state_q == S_SCAN && !match && (idx_inc < nrules)) begin
			rule_re    = 1'b1;
			rule_raddr = idx_inc[RULE_AW-1:0];
		end
	end

	assign tape_re    = acc && (op == OP_STEP) && !halted_q && !head_off;
	assign tape_raddr = head_taddr;

	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = slot_ext[TAPE_AW-1:0];
		tape_wdata = cell_value;
		if (state_q == S_IDLE) begin
			tape_we = acc && (op == OP_CELL) && slot_tape_ok;
		end else if (state_q == S_SCAN && match) begin
			tape_we    = 1'b1;
			tape_waddr = head_taddr;
			tape_wdata = rule.wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= HEAD_W'(1);
			cur_q    <= '0;
			halted_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_DONE;
						case (op)
							OP_START: begin
								cur_q    <= '0;
								head_q   <= HEAD_W'(cfg.start_head);
								halted_q <= 1'b0;
							end
							OP_STEP: begin
								if (!halted_q) begin
									if (head_off) begin
										halted_q <= 1'b1;
									end else begin
										state_q <= S_TREAD;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_TREAD: begin
					if (nrules == '0) begin
						halted_q <= 1'b1;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match) begin
						cur_q   <= rule.nxt;
						head_q  <= new_head;
						state_q <= S_DONE;
						if (new_off) begin
							halted_q <= 1'b1;
						end
					end else if (!(idx_inc < nrules)) begin
						halted_q <= 1'b1;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_rd_q     <= '0;
				res_status_q <= ST_DONE_OK;
				if (acc && op == OP_STEP) begin
					res_status_q <= halted_q ? ST_WAS_HALT : ST_OFF_TAPE;
				end
			end
			S_TREAD: begin
				rd_q         <= tape_rdata;
				idx_q        <= '0;
				res_rd_q     <= tape_rdata;
				res_status_q <= ST_NO_RULE;
			end
			S_SCAN: begin
				idx_q <= idx_inc;
				if (match) begin
					res_status_q <= new_off ? ST_OFF_TAPE : ST_STEPPED;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_head_q   <= head_q[8:0];
			rsp_state_q  <= cur_ext[7:0];
			rsp_rd_q     <= res_rd_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign head_position = rsp_head_q;
	assign machine_state = rsp_state_q;
	assign read_symbol   = rsp_rd_q;

endmodule

### hw/rtl/turing_machine_step_engine.sv
// Channel   Handshake                  Payload
// request   req_valid / req_stall      op, slot, rule_state, rule_symbol, write_symbol,
//                                      move_right, rule_next_state, cell_value
// response  rsp_valid / rsp_stall      status, head_position, machine_state, read_symbol
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Loads, start and a step on a halted machine or an off-tape head go from idle to done.
// A step reads the tape cell, then scans rules in turn; rule memory is read once a cycle.
// Reset sets state 0 and head position 1, clears halted and restores register defaults.
// A stalled response waits in its output register while the next request is taken.

module turing_machine_step_engine
	import tme_pkg::*;
#(
	parameter int MAX_RULES  = MAX_RULES_DEF,
	parameter int TAPE_CELLS = TAPE_CELLS_DEF,
	parameter int STATE_BITS = STATE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] op,
	input  logic [7:0] slot,
	input  logic [7:0] rule_state,
	input  logic [7:0] rule_symbol,
	input  logic [7:0] write_symbol,
	input  logic       move_right,
	input  logic [7:0] rule_next_state,
	input  logic [7:0] cell_value,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [2:0] status,
	output logic [8:0] head_position,
	output logic [7:0] machine_state,
	output logic [7:0] read_symbol,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int RULE_W  = 2 * STATE_BITS + 2 * SYM_W + 1;
	localparam int RULE_AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int TAPE_AW = $clog2(TAPE_CELLS);

	cfg_t               cfg_q;
	logic               rule_we;
	logic [RULE_AW-1:0] rule_waddr;
	logic [RULE_W-1:0]  rule_wdata;
	logic               rule_re;
	logic [RULE_AW-1:0] rule_raddr;
	logic [RULE_W-1:0]  rule_rdata;
	logic               tape_we;
	logic [TAPE_AW-1:0] tape_waddr;
	logic [SYM_W-1:0]   tape_wdata;
	logic               tape_re;
	logic [TAPE_AW-1:0] tape_raddr;
	logic [SYM_W-1:0]   tape_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rule_count  <= RULE_COUNT_RST;
			cfg_q.tape_length <= TAPE_LENGTH_RST;
			cfg_q.start_head  <= START_HEAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RULE_COUNT:  cfg_q.rule_count  <= cfg_data[6:0];
				CFG_TAPE_LENGTH: cfg_q.tape_length <= cfg_data;
				CFG_START_HEAD:  cfg_q.start_head  <= cfg_data;
				default: ;
			endcase
		end
	end

	tme_ram #(
		.WIDTH (RULE_W),
		.DEPTH (MAX_RULES),
		.AW    (RULE_AW)
	) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.re    (rule_re),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);

	tme_ram #(
		.WIDTH (SYM_W),
		.DEPTH (TAPE_CELLS),
		.AW    (TAPE_AW)
	) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (tape_re),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	tme_ctrl #(
		.MAX_RULES  (MAX_RULES),
		.TAPE_CELLS (TAPE_CELLS),
		.STATE_BITS (STATE_BITS),
		.RULE_W     (RULE_W),
		.RULE_AW    (RULE_AW),
		.TAPE_AW    (TAPE_AW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.op              (op),
		.slot            (slot),
		.rule_state      (rule_state),
		.rule_symbol     (rule_symbol),
		.write_symbol    (write_symbol),
		.move_right      (move_right),
		.rule_next_state (rule_next_state),
		.cell_value      (cell_value),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.head_position   (head_position),
		.machine_state   (machine_state),
		.read_symbol     (read_symbol),
		.rule_we         (rule_we),
		.rule_waddr      (rule_waddr),
		.rule_wdata      (rule_wdata),
		.rule_re         (rule_re),
		.rule_raddr      (rule_raddr),
		.rule_rdata      (rule_rdata),
		.tape_we         (tape_we),
		.tape_waddr      (tape_waddr),
		.tape_wdata      (tape_wdata),
		.tape_re         (tape_re),
		.tape_raddr      (tape_raddr),
		.tape_rdata      (tape_rdata)
	);

endmodule
